/* hw/rtl/adl_pkg.sv */
package adl_pkg;

	// Default parameter values for the top level.
	localparam int PRICE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed field widths of the words on the ports.
	localparam int FIELD_BITS = 32;
	localparam int LINE_BITS  = 64;

	// The ratio code is clipped to plus or minus 2^RATIO_LOG2.
	localparam int RATIO_LOG2 = 24;
	localparam int CODE_BITS  = RATIO_LOG2 + 1;
	localparam int PROD_BITS  = CODE_BITS + FIELD_BITS;

	// One price bar.
	typedef struct packed {
		logic [FIELD_BITS-1:0] bar_high;
		logic [FIELD_BITS-1:0] bar_low;
		logic [FIELD_BITS-1:0] bar_close;
		logic [FIELD_BITS-1:0] bar_volume;
		logic                  series_start;
		logic                  series_end;
	} bar_word_t;

	// One line value.
	typedef struct packed {
		logic signed [LINE_BITS-1:0] line_value;
		logic                        last_of_series;
		logic                        saturated;
	} line_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic mul;
		logic acc;
	} adl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic active;
	} adl_status_t;

endpackage

/* hw/rtl/adl_dp.sv */
module adl_dp #(
	parameter int PRICE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  adl_pkg::adl_cmd_t   cmd,
	output adl_pkg::adl_status_t sts,
	input  adl_pkg::bar_word_t  bar_word,
	output adl_pkg::line_word_t res_word
);
	import adl_pkg::*;

	localparam int PW = (PRICE_BITS < FIELD_BITS) ? PRICE_BITS : FIELD_BITS;
	localparam int NW = PW + 2;
	localparam int DW = PW + 1 + FRAC_BITS;
	localparam int QW = (DW > CODE_BITS) ? DW : CODE_BITS;
	localparam logic [QW-1:0] RLIMIT = QW'(1) << RATIO_LOG2;
	localparam logic signed [LINE_BITS-1:0] LINE_MAX = {1'b0, {(LINE_BITS-1){1'b1}}};
	localparam logic signed [LINE_BITS-1:0] LINE_MIN = {1'b1, {(LINE_BITS-1){1'b0}}};

	logic [PW-1:0]         high_q, low_q, close_q;
	logic [FIELD_BITS-1:0] vol_q;
	logic                  start_q, end_q;
	logic [PW-1:0]         den_q;
	logic                  neg_q, active_q;
	logic [PW-1:0]         rem_q;
	logic [DW-1:0]         dq_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic                  clip_q;
	logic signed [LINE_BITS-1:0] total_q;
	line_word_t            out_q;

	logic [NW-1:0]   num;
	logic [NW-1:0]   num_abs;
	logic [PW:0]     trial;
	logic            fits;
	logic [QW-1:0]   quo;
	logic            clip;
	logic [CODE_BITS-1:0] code;
	logic signed [LINE_BITS-1:0] base, sprod, sum, next_total;
	logic            ovf;

	// Signed numerator 2*close - low - high and its magnitude.
	always_comb begin
		num     = ({2'b00, close_q} << 1) - {2'b00, low_q} - {2'b00, high_q};
		num_abs = num[NW-1] ? (~num + NW'(1)) : num;
	end

	// One restoring division step: shift in one dividend bit, subtract if it fits.
	always_comb begin
		trial = {rem_q, dq_q[DW-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// Ratio code clipped at the limit.
	always_comb begin
		quo  = QW'(dq_q);
		clip = (quo > RLIMIT) || ((quo == RLIMIT) && (rem_q != '0));
		code = clip ? RLIMIT[CODE_BITS-1:0] : quo[CODE_BITS-1:0];
	end

	// Saturating accumulate.
	always_comb begin
		base  = start_q ? '0 : total_q;
		sprod = neg_q ? -$signed(LINE_BITS'(prod_q)) : $signed(LINE_BITS'(prod_q));
		sum   = base + sprod;
		ovf   = (base[LINE_BITS-1] == sprod[LINE_BITS-1]) &&
			(sum[LINE_BITS-1] != base[LINE_BITS-1]);
		if (ovf) begin
			next_total = base[LINE_BITS-1] ? LINE_MIN : LINE_MAX;
		end else begin
			next_total = sum;
		end
	end

	// Bar capture, preparation, division, product and output registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			high_q  <= bar_word.bar_high[PW-1:0];
			low_q   <= bar_word.bar_low[PW-1:0];
			close_q <= bar_word.bar_close[PW-1:0];
			vol_q   <= bar_word.bar_volume;
			start_q <= bar_word.series_start;
			end_q   <= bar_word.series_end;
		end
		if (cmd.prep) begin
			den_q    <= high_q - low_q;
			neg_q    <= num[NW-1];
			active_q <= high_q > low_q;
			rem_q    <= '0;
			dq_q     <= {num_abs[PW:0], {FRAC_BITS{1'b0}}};
		end
		if (cmd.div_step) begin
			rem_q <= fits ? PW'(trial - {1'b0, den_q}) : trial[PW-1:0];
			dq_q  <= {dq_q[DW-2:0], fits};
		end
		if (cmd.mul) begin
			prod_q <= active_q ? (PROD_BITS'(code) * PROD_BITS'(vol_q)) : '0;
			clip_q <= active_q & clip;
		end
		if (cmd.acc) begin
			out_q.line_value     <= next_total;
			out_q.last_of_series <= end_q;
			out_q.saturated      <= clip_q | ovf;
		end
	end

	// Running total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.acc) begin
			total_q <= next_total;
		end
	end

	// The captured bar decides during preparation whether the divider runs.
	assign sts.active = high_q > low_q;
	assign res_word   = out_q;

`ifndef SYNTHESIS
	// The product of a clipped code and a 32-bit volume stays below 2^56.
	a_prod_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> prod_q[PROD_BITS-1] == 1'b0)
		else $error("product exceeds its range");

	// A flat or inverted bar adds nothing and never clips the ratio.
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul && !active_q |=> prod_q == '0 && !clip_q)
		else $error("flat bar produced a nonzero product");

	// The remainder stays below the divisor during an active division.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && active_q |=> rem_q < den_q)
		else $error("division remainder not below divisor");
`endif

endmodule

/* hw/rtl/adl_ctrl.sv */
module adl_ctrl #(
	parameter int DIV_STEPS = 49
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bar_valid,
	output logic                 bar_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	output adl_pkg::adl_cmd_t    cmd,
	input  adl_pkg::adl_status_t sts
);
	import adl_pkg::*;

	localparam int CW = $clog2(DIV_STEPS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          slot_free;
	logic          div_last;

	assign bar_ready = state_q == ST_IDLE;
	assign res_valid = out_valid_q;
	assign slot_free = !out_valid_q || res_ready;
	assign div_last  = cnt_q == CW'(DIV_STEPS - 1);

	// Commands for the datapath.
	always_comb begin
		cmd.load     = bar_valid && bar_ready;
		cmd.prep     = state_q == ST_PREP;
		cmd.div_step = state_q == ST_DIV;
		cmd.mul      = state_q == ST_MUL;
		cmd.acc      = (state_q == ST_ACC) && slot_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (bar_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = sts.active ? ST_DIV : ST_MUL;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, step counter and output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.acc) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// An accepted word always starts preparation in the next cycle.
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_ready |=> state_q == ST_PREP)
		else $error("accepted word did not start preparation");

	// The step counter never runs past the last division step.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= CW'(DIV_STEPS - 1))
		else $error("division step counter overran");

	// Accumulating always leaves a word waiting at the output.
	a_acc_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |=> out_valid_q && state_q == ST_IDLE)
		else $error("accumulate did not present an output word");
`endif

endmodule

/* hw/rtl/accumulation_distribution_line.sv */
// Accumulation/distribution line.
// The bar channel (bar_valid, bar_ready, bar_word) takes one price bar per
// word: high, low, close, volume and the series flags. The result channel
// (res_valid, res_ready, res_word) returns exactly one word per bar: the
// running line value with FRAC_BITS fraction bits, a copy of series_end and
// a saturation flag. Each bar's close location value is found by a restoring
// divider that retires one quotient bit per cycle. A bar passes through
// preparation, division, multiply and accumulate steps in that order, and
// the next bar is taken only once the previous bar has been accumulated.
// A flat or inverted bar skips the divider and goes from preparation to the
// multiply step. bar_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new bar is accepted while the
// previous result waits; if the receiver stalls, the next bar completes
// and then holds in the accumulate step until the output register empties.
// Reset clears the running total to zero and empties the output register.
module accumulation_distribution_line #(
	parameter int PRICE_BITS = adl_pkg::PRICE_BITS_DEF,
	parameter int FRAC_BITS  = adl_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bar_valid,
	output logic                bar_ready,
	input  adl_pkg::bar_word_t  bar_word,
	output logic                res_valid,
	input  logic                res_ready,
	output adl_pkg::line_word_t res_word
);
	import adl_pkg::*;

	localparam int PW = (PRICE_BITS < FIELD_BITS) ? PRICE_BITS : FIELD_BITS;
	localparam int DIV_STEPS = PW + 1 + FRAC_BITS;

	adl_cmd_t    cmd;
	adl_status_t sts;

	// Sequencer.
	adl_ctrl #(
		.DIV_STEPS(DIV_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.bar_valid(bar_valid),
		.bar_ready(bar_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Divider, multiplier and accumulator.
	adl_dp #(
		.PRICE_BITS(PRICE_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.bar_word(bar_word),
		.res_word(res_word)
	);

endmodule
